>>> hdl/lfn_pkg.sv
package lfn_pkg;

   // default sizes
   localparam int MAX_INSTANCES_DEF = 1024;
   localparam int MAX_FEATURES_DEF  = 64;
   localparam int OUT_BITS_DEF      = 16;

   // register map
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 11;
   localparam logic [CSR_INDEX_W-1:0] REG_FEATURE_COUNT  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_INSTANCE_COUNT = 2'd1;
   localparam logic [6:0]  FEATURE_COUNT_RESET  = 7'd1;
   localparam logic [10:0] INSTANCE_COUNT_RESET = 11'd4;

   // fixed point constants
   localparam logic [32:0] ONE_Q32      = 33'h1_0000_0000;
   localparam logic [43:0] Z_LIMIT      = 44'hF_FFFF;
   localparam logic [3:0]  TAYLOR_TERMS = 4'd10;

   // input word
   typedef struct packed {
      logic              mode;
      logic signed [31:0] sample_value;
   } req_type;

   // result word
   typedef struct packed {
      logic [15:0] norm_value;
      logic [5:0]  feature_index;
      logic [9:0]  instance_index;
      logic        last_value;
      logic        status;
   } rsp_type;

   // divider request
   typedef struct packed {
      logic        start;
      logic [63:0] dividend;
      logic [63:0] divisor;
   } div_req_type;

   // floor(2^32 / m) estimate for the series terms, m = 1 is one below 2^32
   function automatic logic [31:0] taylor_recip(input logic [3:0] m);
      logic [31:0] r;
      case (m)
         4'd1:    r = 32'hFFFF_FFFF;
         4'd2:    r = 32'h8000_0000;
         4'd3:    r = 32'h5555_5555;
         4'd4:    r = 32'h4000_0000;
         4'd5:    r = 32'h3333_3333;
         4'd6:    r = 32'h2AAA_AAAA;
         4'd7:    r = 32'h2492_4924;
         4'd8:    r = 32'h2000_0000;
         4'd9:    r = 32'h1C71_C71C;
         4'd10:   r = 32'h1999_9999;
         default: r = 32'h0;
      endcase
      return r;
   endfunction

endpackage

>>> hdl/lfn_ram.sv
module lfn_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 32
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                     wr_data,
   input  logic                                 rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/lfn_divider.sv
module lfn_divider (
   input  logic                clock,
   input  logic                reset,
   input  lfn_pkg::div_req_type div_req,
   output logic                div_done,
   output logic [63:0]         div_quo
);

   import lfn_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [63:0] rem_ff, rem_in;
   logic [63:0] quo_ff, quo_in;
   logic [63:0] dsr_ff, dsr_in;
   logic [64:0] shifted;
   logic [64:0] diff;
   logic        ge;

   // restoring step, one quotient bit per cycle
   assign shifted = {rem_ff, quo_ff[63]};
   assign diff    = shifted - {1'b0, dsr_ff};
   assign ge      = (shifted >= {1'b0, dsr_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = 7'd64;
         rem_in  = 64'd0;
         quo_in  = div_req.dividend;
         dsr_in  = div_req.divisor;
      end else if (busy_ff) begin
         rem_in = ge ? diff[63:0] : shifted[63:0];
         quo_in = {quo_ff[62:0], ge};
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 7'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign div_done = done_ff;
   assign div_quo  = quo_ff;

endmodule

>>> hdl/lfn_isqrt.sv
module lfn_isqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        sqrt_start,
   input  logic [63:0] sqrt_value,
   output logic        sqrt_done,
   output logic [31:0] sqrt_root
);

   import lfn_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [33:0] rem_ff, rem_in;
   logic [31:0] root_ff, root_in;
   logic [63:0] val_ff, val_in;
   logic [35:0] trial;
   logic [35:0] cand;
   logic        ge;

   // two radicand bits per cycle, one root bit
   assign trial = {rem_ff, val_ff[63:62]};
   assign cand  = {2'b00, root_ff, 2'b01};
   assign ge    = (trial >= cand);

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      val_in  = val_ff;
      if (sqrt_start) begin
         busy_in = 1'b1;
         cnt_in  = 6'd32;
         rem_in  = 34'd0;
         root_in = 32'd0;
         val_in  = sqrt_value;
      end else if (busy_ff) begin
         if (ge) begin
            rem_in = 34'(trial - cand);
         end else begin
            rem_in = trial[33:0];
         end
         root_in = {root_ff[30:0], ge};
         val_in  = {val_ff[61:0], 2'b00};
         cnt_in  = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 6'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      root_ff <= root_in;
      val_ff  <= val_in;
   end

   assign sqrt_done = done_ff;
   assign sqrt_root = root_ff;

endmodule

>>> hdl/logistic_feature_normalizer_core.sv
// load word: accepted while idle, no result
// final load of a set starts a statistics pass per feature: two walks of the sample memory,
//   two divisions and, unless the variance is zero, a third division and a root
// read word: result from the series loop on the shared multiplier and one division, or a
//   status word before statistics exist; one word is worked on at a time
// reset clears counters and flags; sample and statistics memories and data registers are undefined
module logistic_feature_normalizer_core #(
   parameter int MAX_INSTANCES = lfn_pkg::MAX_INSTANCES_DEF,
   parameter int MAX_FEATURES  = lfn_pkg::MAX_FEATURES_DEF,
   parameter int OUT_BITS      = lfn_pkg::OUT_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  lfn_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output lfn_pkg::rsp_type                   rsp_data,
   input  logic                               csr_write_enable,
   input  logic [lfn_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [lfn_pkg::CSR_DATA_W-1:0]     csr_write_data
);

   import lfn_pkg::*;

   localparam int DEPTH  = MAX_INSTANCES * MAX_FEATURES;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int TOT_W  = $clog2(DEPTH + 1);
   localparam int NF_W   = $clog2(MAX_FEATURES + 1);
   localparam int NI_W   = $clog2(MAX_INSTANCES + 1);
   localparam int FEAT_W = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
   localparam int INST_W = $clog2(MAX_INSTANCES);
   localparam int SUM_W  = 32 + $clog2(MAX_INSTANCES);
   localparam int SH     = 32 - OUT_BITS;
   localparam int SHM1   = (SH > 0) ? SH - 1 : 0;
   localparam logic [33:0] HALF = (SH > 0) ? (34'd1 << SHM1) : 34'd0;
   localparam logic [33:0] MAXV = (34'd1 << OUT_BITS) - 34'd1;

   // sequencer states
   localparam logic [4:0] ST_IDLE   = 5'd0;
   localparam logic [4:0] ST_INIT   = 5'd1;
   localparam logic [4:0] ST_SUM    = 5'd2;
   localparam logic [4:0] ST_MDIV   = 5'd3;
   localparam logic [4:0] ST_VAR    = 5'd4;
   localparam logic [4:0] ST_VDIV   = 5'd5;
   localparam logic [4:0] ST_IDIV   = 5'd6;
   localparam logic [4:0] ST_SQRT   = 5'd7;
   localparam logic [4:0] ST_WSTAT  = 5'd8;
   localparam logic [4:0] ST_RDIF   = 5'd9;
   localparam logic [4:0] ST_RZ     = 5'd10;
   localparam logic [4:0] ST_RCLAMP = 5'd11;
   localparam logic [4:0] ST_HMUL   = 5'd12;
   localparam logic [4:0] ST_HTERM  = 5'd13;
   localparam logic [4:0] ST_HREC   = 5'd14;
   localparam logic [4:0] ST_HQUO   = 5'd15;
   localparam logic [4:0] ST_HCORR  = 5'd16;
   localparam logic [4:0] ST_SQ     = 5'd17;
   localparam logic [4:0] ST_SQW    = 5'd18;
   localparam logic [4:0] ST_SDIV   = 5'd19;
   localparam logic [4:0] ST_RFIN   = 5'd20;
   localparam logic [4:0] ST_OUT    = 5'd21;

   logic [4:0]        state_ff, state_in;
   logic [6:0]        cfg_fc_ff, cfg_fc_in;
   logic [10:0]       cfg_ic_ff, cfg_ic_in;
   logic [TOT_W-1:0]  load_count_ff, load_count_in;
   logic [TOT_W-1:0]  rp_ff, rp_in;
   logic [FEAT_W-1:0] feat_ff, feat_in;
   logic [INST_W-1:0] inst_ff, inst_in;
   logic              stats_ready_ff, stats_ready_in;
   logic [FEAT_W-1:0] j_ff, j_in;
   logic [NI_W-1:0]   iss_ff, iss_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic              v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [63:0]       acc_ff, acc_in;
   logic [31:0]       mean_ff, mean_in;
   logic [31:0]       inv_ff, inv_in;
   logic [31:0]       ad_ff, ad_in;
   logic              neg_ff, neg_in;
   logic [31:0]       r_ff, r_in;
   logic [32:0]       p_ff, p_in;
   logic [3:0]        m_ff, m_in;
   logic [1:0]        k_ff, k_in;
   logic [31:0]       t_ff, t_in;
   logic [31:0]       q_ff, q_in;
   logic [32:0]       s_ff, s_in;
   rsp_type           pend_ff, pend_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;
   div_req_type       div_req_ff, div_req_in;
   logic              sqrt_start_ff, sqrt_start_in;
   logic [63:0]       sqrt_val_ff, sqrt_val_in;
   logic [63:0]       mul_ff;
   logic [31:0]       mul_a, mul_b;

   logic              div_done;
   logic [63:0]       div_quo;
   logic              sqrt_done;
   logic [31:0]       sqrt_root;

   logic              st_we, st_re;
   logic [ADDR_W-1:0] st_waddr, st_raddr;
   logic [31:0]       st_wdata, st_rdata;
   logic              sm_we, sm_re;
   logic [FEAT_W-1:0] sm_waddr, sm_raddr;
   logic [63:0]       sm_wdata, sm_rdata;

   logic [31:0]       fc_wide, ic_wide, nf_wide, ni_wide, total_wide;
   logic [NF_W-1:0]   nf;
   logic [NI_W-1:0]   ni;
   logic [TOT_W-1:0]  total;
   logic              accept;
   logic [TOT_W-1:0]  eff_count, new_count;
   logic [SUM_W-1:0]  abs_sum;
   logic [32:0]       d_var, d_rd, dn_var, dn_rd;
   logic [31:0]       rd_mean;
   logic [43:0]       z_raw;
   logic [35:0]       qm, corr_rem;
   logic [32:0]       p_sq;
   logic [32:0]       s_fin;
   logic [33:0]       s_rnd, s_shift;
   logic [64:0]       acc_sum;

   // clamp the registers to their usable ranges
   assign fc_wide    = 32'(cfg_fc_ff);
   assign ic_wide    = 32'(cfg_ic_ff);
   assign nf_wide    = (fc_wide < 32'd1) ? 32'd1 :
                       (fc_wide > 32'(MAX_FEATURES)) ? 32'(MAX_FEATURES) : fc_wide;
   assign ni_wide    = (ic_wide < 32'd4) ? 32'd4 :
                       (ic_wide > 32'(MAX_INSTANCES)) ? 32'(MAX_INSTANCES) : ic_wide;
   assign total_wide = nf_wide * ni_wide;
   assign nf         = nf_wide[NF_W-1:0];
   assign ni         = ni_wide[NI_W-1:0];
   assign total      = total_wide[TOT_W-1:0];

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);

   // loads after a finished set start again at entry zero
   assign eff_count = stats_ready_ff ? '0 : load_count_ff;
   assign new_count = (eff_count < total) ? eff_count + TOT_W'(1) : eff_count;

   // datapath helpers
   assign abs_sum  = sum_ff[SUM_W-1] ? (SUM_W'(0) - sum_ff) : sum_ff;
   assign d_var    = {st_rdata[31], st_rdata} - {mean_ff[31], mean_ff};
   assign dn_var   = 33'd0 - d_var;
   assign rd_mean  = sm_rdata[31:0];
   assign d_rd     = {st_rdata[31], st_rdata} - {rd_mean[31], rd_mean};
   assign dn_rd    = 33'd0 - d_rd;
   assign z_raw    = mul_ff[63:20];
   assign qm       = 36'(q_ff) * 36'(m_ff);
   assign corr_rem = {4'd0, t_ff} - qm;
   assign p_sq     = p_ff[32] ? ONE_Q32 : {1'b0, mul_ff[63:32]};
   assign s_fin    = neg_ff ? (ONE_Q32 - s_ff) : s_ff;
   assign s_rnd    = {1'b0, s_fin} + HALF;
   assign s_shift  = s_rnd >> SH;
   assign acc_sum  = {1'b0, acc_ff} + {9'd0, mul_ff[63:8]};

   // shared multiplier, operands chosen by state
   always_comb begin
      mul_a = 32'd0;
      mul_b = 32'd0;
      case (state_ff)
         ST_VAR: begin
            mul_a = ad_ff;
            mul_b = ad_ff;
         end
         ST_RZ: begin
            mul_a = ad_ff;
            mul_b = inv_ff;
         end
         ST_HMUL: begin
            mul_a = r_ff;
            mul_b = p_ff[31:0];
         end
         ST_HREC: begin
            mul_a = t_ff;
            mul_b = taylor_recip(m_ff);
         end
         ST_SQ: begin
            mul_a = p_ff[31:0];
            mul_b = p_ff[31:0];
         end
         default: begin
            mul_a = 32'd0;
            mul_b = 32'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      mul_ff <= 64'(mul_a) * 64'(mul_b);
   end

   // sequencer
   always_comb begin
      state_in       = state_ff;
      cfg_fc_in      = cfg_fc_ff;
      cfg_ic_in      = cfg_ic_ff;
      load_count_in  = load_count_ff;
      rp_in          = rp_ff;
      feat_in        = feat_ff;
      inst_in        = inst_ff;
      stats_ready_in = stats_ready_ff;
      j_in           = j_ff;
      iss_in         = iss_ff;
      addr_in        = addr_ff;
      v1_in          = 1'b0;
      v2_in          = v1_ff;
      v3_in          = v2_ff;
      sum_in         = sum_ff;
      acc_in         = acc_ff;
      mean_in        = mean_ff;
      inv_in         = inv_ff;
      ad_in          = ad_ff;
      neg_in         = neg_ff;
      r_in           = r_ff;
      p_in           = p_ff;
      m_in           = m_ff;
      k_in           = k_ff;
      t_in           = t_ff;
      q_in           = q_ff;
      s_in           = s_ff;
      pend_in        = pend_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_data_in    = rsp_data_ff;
      div_req_in     = div_req_ff;
      div_req_in.start = 1'b0;
      sqrt_start_in  = 1'b0;
      sqrt_val_in    = sqrt_val_ff;
      st_we          = 1'b0;
      st_waddr       = eff_count[ADDR_W-1:0];
      st_wdata       = req_data.sample_value;
      st_re          = 1'b0;
      st_raddr       = addr_ff;
      sm_we          = 1'b0;
      sm_waddr       = j_ff;
      sm_wdata       = {inv_ff, mean_ff};
      sm_re          = 1'b0;
      sm_raddr       = feat_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept && !req_data.mode) begin
               // store the sample, start statistics once the set is full
               st_we          = (eff_count < total);
               load_count_in  = new_count;
               stats_ready_in = 1'b0;
               if (stats_ready_ff) begin
                  rp_in   = '0;
                  feat_in = '0;
                  inst_in = '0;
               end
               if (new_count >= total) begin
                  j_in     = '0;
                  state_in = ST_INIT;
               end
            end else if (accept) begin
               if (!stats_ready_ff) begin
                  pend_in        = '0;
                  pend_in.status = 1'b1;
                  state_in       = ST_OUT;
               end else begin
                  st_re    = 1'b1;
                  st_raddr = rp_ff[ADDR_W-1:0];
                  sm_re    = 1'b1;
                  state_in = ST_RDIF;
               end
            end
         end

         ST_INIT: begin
            sum_in   = '0;
            acc_in   = 64'd0;
            iss_in   = '0;
            addr_in  = ADDR_W'(j_ff);
            state_in = ST_SUM;
         end

         // first column walk: sum
         ST_SUM: begin
            if (iss_ff < ni) begin
               st_re   = 1'b1;
               v1_in   = 1'b1;
               iss_in  = iss_ff + NI_W'(1);
               addr_in = addr_ff + ADDR_W'(nf);
            end
            if (v1_ff) begin
               sum_in = sum_ff + {{(SUM_W-32){st_rdata[31]}}, st_rdata};
            end
            if (iss_ff == ni && !v1_ff) begin
               div_req_in = '{start: 1'b1, dividend: 64'(abs_sum), divisor: 64'(ni)};
               state_in   = ST_MDIV;
            end
         end

         ST_MDIV: begin
            if (div_done) begin
               mean_in  = sum_ff[SUM_W-1] ? (32'd0 - div_quo[31:0]) : div_quo[31:0];
               iss_in   = '0;
               addr_in  = ADDR_W'(j_ff);
               state_in = ST_VAR;
            end
         end

         // second column walk: squared deviations, read / diff / square / add
         ST_VAR: begin
            if (iss_ff < ni) begin
               st_re   = 1'b1;
               v1_in   = 1'b1;
               iss_in  = iss_ff + NI_W'(1);
               addr_in = addr_ff + ADDR_W'(nf);
            end
            if (v1_ff) begin
               ad_in = d_var[32] ? dn_var[31:0] : d_var[31:0];
            end
            if (v3_ff) begin
               acc_in = acc_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : acc_sum[63:0];
            end
            if (iss_ff == ni && !v1_ff && !v2_ff && !v3_ff) begin
               div_req_in = '{start: 1'b1, dividend: acc_ff,
                              divisor: 64'(ni) - 64'd1};
               state_in   = ST_VDIV;
            end
         end

         ST_VDIV: begin
            if (div_done) begin
               if (div_quo == 64'd0) begin
                  inv_in   = 32'd0;
                  state_in = ST_WSTAT;
               end else begin
                  div_req_in = '{start: 1'b1, dividend: 64'hFFFF_FFFF_FFFF_FFFF,
                                 divisor: div_quo};
                  state_in   = ST_IDIV;
               end
            end
         end

         ST_IDIV: begin
            if (div_done) begin
               sqrt_start_in = 1'b1;
               sqrt_val_in   = div_quo;
               state_in      = ST_SQRT;
            end
         end

         ST_SQRT: begin
            if (sqrt_done) begin
               inv_in   = sqrt_root;
               state_in = ST_WSTAT;
            end
         end

         ST_WSTAT: begin
            sm_we = 1'b1;
            if (NF_W'(j_ff) == nf - NF_W'(1)) begin
               stats_ready_in = 1'b1;
               rp_in          = '0;
               feat_in        = '0;
               inst_in        = '0;
               state_in       = ST_IDLE;
            end else begin
               j_in     = j_ff + FEAT_W'(1);
               state_in = ST_INIT;
            end
         end

         // read path: deviation from the mean
         ST_RDIF: begin
            neg_in   = d_rd[32];
            ad_in    = d_rd[32] ? dn_rd[31:0] : d_rd[31:0];
            inv_in   = sm_rdata[63:32];
            state_in = ST_RZ;
         end

         ST_RZ: begin
            state_in = ST_RCLAMP;
         end

         ST_RCLAMP: begin
            r_in     = (z_raw > Z_LIMIT) ? {Z_LIMIT[19:0], 12'd0} : {z_raw[19:0], 12'd0};
            p_in     = ONE_Q32;
            m_in     = TAYLOR_TERMS;
            state_in = ST_HMUL;
         end

         // series step: p = 1 - ((r * p) >> 32) / m
         ST_HMUL: begin
            state_in = ST_HTERM;
         end

         ST_HTERM: begin
            t_in     = p_ff[32] ? r_ff : mul_ff[63:32];
            state_in = ST_HREC;
         end

         ST_HREC: begin
            state_in = ST_HQUO;
         end

         ST_HQUO: begin
            q_in     = mul_ff[63:32];
            state_in = ST_HCORR;
         end

         ST_HCORR: begin
            if (corr_rem >= 36'(m_ff)) begin
               q_in = q_ff + 32'd1;
            end else begin
               p_in = ONE_Q32 - {1'b0, q_ff};
               if (m_ff == 4'd1) begin
                  k_in     = 2'd0;
                  state_in = ST_SQ;
               end else begin
                  m_in     = m_ff - 4'd1;
                  state_in = ST_HMUL;
               end
            end
         end

         // four squarings
         ST_SQ: begin
            state_in = ST_SQW;
         end

         ST_SQW: begin
            p_in = p_sq;
            if (k_ff == 2'd3) begin
               div_req_in = '{start: 1'b1, dividend: 64'hFFFF_FFFF_FFFF_FFFF,
                              divisor: 64'({1'b0, ONE_Q32} + {1'b0, p_sq})};
               state_in   = ST_SDIV;
            end else begin
               k_in     = k_ff + 2'd1;
               state_in = ST_SQ;
            end
         end

         ST_SDIV: begin
            if (div_done) begin
               s_in     = div_quo[32:0];
               state_in = ST_RFIN;
            end
         end

         // round, saturate, step the read pointer
         ST_RFIN: begin
            pend_in.norm_value     = (s_shift > MAXV) ? MAXV[15:0] : s_shift[15:0];
            pend_in.feature_index  = 6'(feat_ff);
            pend_in.instance_index = 10'(inst_ff);
            pend_in.last_value     = (rp_ff + TOT_W'(1) == total);
            pend_in.status         = 1'b0;
            if (rp_ff + TOT_W'(1) >= total) begin
               rp_in   = '0;
               feat_in = '0;
               inst_in = '0;
            end else begin
               rp_in = rp_ff + TOT_W'(1);
               if (NF_W'(feat_ff) + NF_W'(1) == nf) begin
                  feat_in = '0;
                  inst_in = inst_ff + INST_W'(1);
               end else begin
                  feat_in = feat_ff + FEAT_W'(1);
               end
            end
            state_in = ST_OUT;
         end

         // hand the word to the output register
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_data_in  = pend_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // writes to the feature or instance count abort the current set
      if (csr_write_enable) begin
         if (csr_index == REG_FEATURE_COUNT) begin
            cfg_fc_in = csr_write_data[6:0];
         end else if (csr_index == REG_INSTANCE_COUNT) begin
            cfg_ic_in = csr_write_data[10:0];
         end
         if (csr_index == REG_FEATURE_COUNT || csr_index == REG_INSTANCE_COUNT) begin
            load_count_in  = '0;
            rp_in          = '0;
            feat_in        = '0;
            inst_in        = '0;
            stats_ready_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         cfg_fc_ff      <= FEATURE_COUNT_RESET;
         cfg_ic_ff      <= INSTANCE_COUNT_RESET;
         load_count_ff  <= '0;
         rp_ff          <= '0;
         feat_ff        <= '0;
         inst_ff        <= '0;
         stats_ready_ff <= 1'b0;
         j_ff           <= '0;
         iss_ff         <= '0;
         v1_ff          <= 1'b0;
         v2_ff          <= 1'b0;
         v3_ff          <= 1'b0;
         m_ff           <= '0;
         k_ff           <= '0;
         rsp_valid_ff   <= 1'b0;
         div_req_ff     <= '0;
         sqrt_start_ff  <= 1'b0;
      end else begin
         state_ff       <= state_in;
         cfg_fc_ff      <= cfg_fc_in;
         cfg_ic_ff      <= cfg_ic_in;
         load_count_ff  <= load_count_in;
         rp_ff          <= rp_in;
         feat_ff        <= feat_in;
         inst_ff        <= inst_in;
         stats_ready_ff <= stats_ready_in;
         j_ff           <= j_in;
         iss_ff         <= iss_in;
         v1_ff          <= v1_in;
         v2_ff          <= v2_in;
         v3_ff          <= v3_in;
         m_ff           <= m_in;
         k_ff           <= k_in;
         rsp_valid_ff   <= rsp_valid_in;
         div_req_ff     <= div_req_in;
         sqrt_start_ff  <= sqrt_start_in;
      end
      addr_ff     <= addr_in;
      sum_ff      <= sum_in;
      acc_ff      <= acc_in;
      mean_ff     <= mean_in;
      inv_ff      <= inv_in;
      ad_ff       <= ad_in;
      neg_ff      <= neg_in;
      r_ff        <= r_in;
      p_ff        <= p_in;
      t_ff        <= t_in;
      q_ff        <= q_in;
      s_ff        <= s_in;
      pend_ff     <= pend_in;
      rsp_data_ff <= rsp_data_in;
      sqrt_val_ff <= sqrt_val_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // sample memory; a stored entry is read no earlier than the cycle after its write
   lfn_ram #(
      .DEPTH (DEPTH),
      .WIDTH (32)
   ) u_sample_ram (
      .clock   (clock),
      .wr_en   (st_we),
      .wr_addr (st_waddr),
      .wr_data (st_wdata),
      .rd_en   (st_re),
      .rd_addr (st_raddr),
      .rd_data (st_rdata)
   );

   // per feature statistics: inverse deviation over mean
   lfn_ram #(
      .DEPTH (MAX_FEATURES),
      .WIDTH (64)
   ) u_stat_ram (
      .clock   (clock),
      .wr_en   (sm_we),
      .wr_addr (sm_waddr),
      .wr_data (sm_wdata),
      .rd_en   (sm_re),
      .rd_addr (sm_raddr),
      .rd_data (sm_rdata)
   );

   lfn_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req_ff),
      .div_done (div_done),
      .div_quo  (div_quo)
   );

   lfn_isqrt u_isqrt (
      .clock      (clock),
      .reset      (reset),
      .sqrt_start (sqrt_start_ff),
      .sqrt_value (sqrt_val_ff),
      .sqrt_done  (sqrt_done),
      .sqrt_root  (sqrt_root)
   );

endmodule

>>> test/logistic_feature_normalizer_core_tb.sv
module logistic_feature_normalizer_core_tb;
   import lfn_pkg::*;

   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_READ = 1'b1;
   localparam int IDLE_LIMIT = 600000;
   localparam int STORE_DEPTH = MAX_INSTANCES_DEF * MAX_FEATURES_DEF;
   localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] ONE_FIX = 64'h1_0000_0000;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   req_type req_data;
   logic rsp_valid;
   logic rsp_ready;
   rsp_type rsp_data;
   logic csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   // shadow state of the normalizer
   logic [31:0] sample_mem [STORE_DEPTH];
   logic [31:0] col_mean [MAX_FEATURES_DEF];
   logic [31:0] col_inv_std [MAX_FEATURES_DEF];
   int unsigned loaded;
   int unsigned rd_ptr;
   bit stats_valid;
   logic [6:0] cfg_features;
   logic [10:0] cfg_instances;

   req_type pending_words[$];
   rsp_type expected_words[$];
   int errors;
   int idle_cycles;
   int burst_left;
   int gap_left;
   int stall_left;
   int ready_style;
   int issued;

   logistic_feature_normalizer_core u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int unsigned used_features();
      if (cfg_features < 1) return 1;
      if (cfg_features > MAX_FEATURES_DEF) return MAX_FEATURES_DEF;
      return cfg_features;
   endfunction

   function automatic int unsigned used_instances();
      if (cfg_instances < 4) return 4;
      if (cfg_instances > MAX_INSTANCES_DEF) return MAX_INSTANCES_DEF;
      return cfg_instances;
   endfunction

   function automatic logic [63:0] isqrt64(input logic [63:0] v);
      logic [63:0] r;
      logic [63:0] b;
      r = 0;
      b = 64'h1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // mean and inverse deviation of every column
   task automatic compute_column_stats();
      int unsigned nf;
      int unsigned ni;
      longint sum;
      longint mean;
      longint d;
      logic [63:0] ad;
      logic [63:0] term;
      logic [63:0] acc;
      logic [63:0] var_q;
      nf = used_features();
      ni = used_instances();
      for (int unsigned j = 0; j < nf; j++) begin
         sum = 0;
         for (int unsigned i = 0; i < ni; i++)
            sum += longint'($signed(sample_mem[i * nf + j]));
         mean = sum / longint'(ni);
         col_mean[j] = mean[31:0];
         acc = 0;
         for (int unsigned i = 0; i < ni; i++) begin
            d = longint'($signed(sample_mem[i * nf + j])) - mean;
            ad = (d < 0) ? -d : d;
            term = (ad * ad) >> 8;
            acc = (acc > ALL_ONES - term) ? ALL_ONES : acc + term;
         end
         var_q = acc / (ni - 1);
         col_inv_std[j] = (var_q == 0) ? 32'd0 : 32'(isqrt64(ALL_ONES / var_q));
      end
   endtask

   // sigmoid of the scaled deviation, q0.16
   function automatic logic [15:0] logistic_q16(input longint d, input logic [31:0] inv);
      logic [63:0] ad;
      logic [63:0] a;
      logic [63:0] r;
      logic [63:0] p;
      logic [63:0] s;
      ad = (d < 0) ? -d : d;
      a = (ad * {32'd0, inv}) >> 20;
      if (a > 64'hF_FFFF) a = 64'hF_FFFF;
      r = a << 12;
      p = ONE_FIX;
      for (int m = TAYLOR_TERMS; m >= 1; m--)
         p = ONE_FIX - (((r * p) >> 32) / m);
      for (int k = 0; k < 4; k++)
         p = (p >= ONE_FIX) ? ONE_FIX : ((p * p) >> 32);
      s = ALL_ONES / (ONE_FIX + p);
      if (d < 0) s = ONE_FIX - s;
      s = (s + 64'h8000) >> 16;
      if (s > 64'hFFFF) s = 64'hFFFF;
      return s[15:0];
   endfunction

   // advance the shadow state by one accepted word
   task automatic apply_word(input req_type w);
      int unsigned nf;
      int unsigned total;
      int unsigned rp;
      rsp_type e;
      nf = used_features();
      total = nf * used_instances();
      if (w.mode == MODE_LOAD) begin
         if (stats_valid) begin
            stats_valid = 0;
            loaded = 0;
            rd_ptr = 0;
         end
         if (loaded < total) begin
            sample_mem[loaded] = w.sample_value;
            loaded++;
         end
         if (loaded >= total) begin
            compute_column_stats();
            stats_valid = 1;
            rd_ptr = 0;
         end
      end else begin
         e = '0;
         if (!stats_valid) begin
            e.status = 1'b1;
         end else begin
            if (rd_ptr >= total) rd_ptr = 0;
            rp = rd_ptr;
            e.norm_value = logistic_q16(longint'($signed(sample_mem[rp]))
               - longint'($signed(col_mean[rp % nf])), col_inv_std[rp % nf]);
            e.feature_index = 6'(rp % nf);
            e.instance_index = 10'(rp / nf);
            e.last_value = (rp + 1 == total);
            rd_ptr = (rp + 1 >= total) ? 0 : rp + 1;
         end
         expected_words.push_back(e);
      end
   endtask

   // driver: bursts of words with gaps
   always @(posedge clock) begin
      req_type w;
      if (reset) begin
         req_valid <= 1'b0;
         req_data <= '0;
         burst_left <= 0;
         gap_left <= 0;
      end else begin
         if (req_valid && req_ready) apply_word(req_data);
         if (req_valid && !req_ready) begin
            req_valid <= 1'b1;
         end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_words.size() > 0) begin
            w = pending_words.pop_front();
            req_valid <= 1'b1;
            req_data <= w;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 24);
               gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor: compare each result word with the oldest expectation
   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left <= 0;
         ready_style <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               $display("%0t unexpected word actual=%h", $time, rsp_data);
               errors++;
            end else begin
               e = expected_words.pop_front();
               if (e.norm_value !== rsp_data.norm_value ||
                   e.feature_index !== rsp_data.feature_index ||
                   e.instance_index !== rsp_data.instance_index ||
                   e.last_value !== rsp_data.last_value ||
                   e.status !== rsp_data.status) begin
                  $display("%0t mismatch norm %h/%h feat %0d/%0d inst %0d/%0d last %b/%b st %b/%b",
                     $time, e.norm_value, rsp_data.norm_value, e.feature_index,
                     rsp_data.feature_index, e.instance_index, rsp_data.instance_index,
                     e.last_value, rsp_data.last_value, e.status, rsp_data.status);
                  errors++;
               end
            end
         end
         // receiver stall pattern: phases of always ready, random and long stalls
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_ready <= 1'b0;
         end else begin
            if ($urandom_range(0, 99) == 0) ready_style <= $urandom_range(0, 2);
            if (ready_style == 1) begin
               rsp_ready <= $urandom_range(0, 1);
            end else if (ready_style == 2 && $urandom_range(0, 3) == 0) begin
               stall_left <= $urandom_range(1, 40);
               rsp_ready <= 1'b0;
            end else begin
               rsp_ready <= 1'b1;
            end
         end
      end
   end

   // watchdog on cycles with no word moving
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      if (idx == REG_FEATURE_COUNT) cfg_features = value[6:0];
      else if (idx == REG_INSTANCE_COUNT) cfg_instances = value;
      if (idx == REG_FEATURE_COUNT || idx == REG_INSTANCE_COUNT) begin
         loaded = 0;
         rd_ptr = 0;
         stats_valid = 0;
      end
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // wait for all words and then for a statistics pass to finish
   task automatic wait_idle();
      wait (pending_words.size() == 0 && !req_valid && expected_words.size() == 0);
      repeat (used_features() * (2 * used_instances() + 240) + 400) @(posedge clock);
   endtask

   task automatic push_word(input logic mode, input logic [31:0] value);
      req_type w;
      w.mode = mode;
      w.sample_value = value;
      pending_words.push_back(w);
      issued++;
   endtask

   function automatic logic [31:0] make_sample(input int style, input logic [31:0] base);
      case (style)
         0: return $urandom;
         1: return base + $urandom_range(0, 255) - 128;
         2: return ($urandom_range(0, 1) == 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
         3: return base;
         default: return base + (($urandom & 32'h000F_FFFF) ^ {32{$urandom_range(0, 1) == 1}});
      endcase
   endfunction

   // one set: optional early reads, loads with occasional reads among them, reads past the end
   task automatic run_set(input int style, input int reads, input bit complete);
      int unsigned total;
      int unsigned n;
      logic [31:0] base;
      total = used_features() * used_instances();
      base = $urandom;
      n = complete ? total : $urandom_range(0, total - 1);
      repeat ($urandom_range(0, 2)) push_word(MODE_READ, $urandom);
      for (int unsigned k = 0; k < n; k++) begin
         push_word(MODE_LOAD, make_sample(style, base));
         if ($urandom_range(0, 40) == 0) push_word(MODE_READ, $urandom);
      end
      repeat (reads) push_word(MODE_READ, $urandom);
   endtask

   initial begin
      logic [31:0] same;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      errors = 0;
      issued = 0;
      loaded = 0;
      rd_ptr = 0;
      stats_valid = 0;
      cfg_features = FEATURE_COUNT_RESET;
      cfg_instances = INSTANCE_COUNT_RESET;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: read before data, extreme samples, wrap, zero deviation
      push_word(MODE_READ, 32'h0);
      push_word(MODE_LOAD, 32'h8000_0000);
      push_word(MODE_LOAD, 32'h7FFF_FFFF);
      push_word(MODE_LOAD, 32'h0000_0000);
      push_word(MODE_READ, 32'hFFFF_FFFF);
      push_word(MODE_LOAD, 32'hFFFF_FFFF);
      repeat (5) push_word(MODE_READ, 32'h0);
      same = 32'h0001_8000;
      repeat (4) push_word(MODE_LOAD, same);
      repeat (2) push_word(MODE_READ, 32'h0);
      wait_idle();
      // unknown indexes leave the set alone
      write_register(2'd2, 11'h7FF);
      write_register(2'd3, 11'h000);
      repeat (3) push_word(MODE_READ, 32'h0);
      wait_idle();

      // extremes of the registers, clamped values among them
      write_register(REG_FEATURE_COUNT, 11'd64);
      write_register(REG_INSTANCE_COUNT, 11'd4);
      run_set(0, 260, 1);
      wait_idle();
      write_register(REG_FEATURE_COUNT, 11'h7FF);
      write_register(REG_INSTANCE_COUNT, 11'd3);
      run_set(4, 20, 1);
      wait_idle();
      write_register(REG_FEATURE_COUNT, 11'h780);
      write_register(REG_INSTANCE_COUNT, 11'h7FF);
      run_set(1, 6, 1);
      wait_idle();
      write_register(REG_INSTANCE_COUNT, 11'd5);
      run_set(0, 3, 1);
      wait_idle();
      write_register(REG_INSTANCE_COUNT, 11'd0);
      run_set(2, 9, 1);
      wait_idle();

      // random sets, mostly small and complete
      while (issued < 2000) begin
         write_register(REG_FEATURE_COUNT,
            {4'($urandom_range(0, 15)), 7'($urandom_range(1, 6))});
         write_register(REG_INSTANCE_COUNT, 11'($urandom_range(2, 12)));
         if ($urandom_range(0, 5) == 0)
            write_register(CSR_INDEX_W'($urandom_range(2, 3)), CSR_DATA_W'($urandom));
         repeat ($urandom_range(1, 3)) begin
            run_set($urandom_range(0, 4), $urandom_range(0, 2 * used_features() *
               used_instances()), $urandom_range(0, 6) != 0);
         end
         wait_idle();
      end

      wait_idle();
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

>>> sim.f
hdl/lfn_pkg.sv
hdl/lfn_ram.sv
hdl/lfn_divider.sv
hdl/lfn_isqrt.sv
hdl/logistic_feature_normalizer_core.sv
test/logistic_feature_normalizer_core_tb.sv
